FILE: src/led_bar_graph_fade_assert.svh
// Assertion macros for the LED bar graph fade block.
// No dependencies; expects aclk and aresetn in the including scope.
`ifndef LED_BAR_GRAPH_FADE_ASSERT_SVH
`define LED_BAR_GRAPH_FADE_ASSERT_SVH

// consequent in the same cycle
`define LBGF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("led bar graph fade: assertion failed");

// consequent in the following cycle
`define LBGF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("led bar graph fade: assertion failed");

`endif

FILE: src/lbgf_pkg.sv
// Shared types, register indices and channel arithmetic for the LED bar graph fade block.
// No dependencies.
package lbgf_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } lbgf_state_t;

    typedef enum logic [1:0] {
        REG_COLOR_BAR0 = 2'd0,
        REG_COLOR_BAR1 = 2'd1,
        REG_FADE_STEP  = 2'd2
    } lbgf_reg_t;

    localparam int CHAN_W  = 8;
    localparam int GRB_W   = 24;
    localparam int INDEX_W = 6;
    localparam int ROUND_BIAS = 127;

    // one 8-bit channel: rise toward target and clamp, or decay to zero
    function automatic logic [CHAN_W-1:0] chan_update(
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] t,
        input logic [CHAN_W-1:0] step,
        input logic              lit
    );
        logic [CHAN_W:0] sum;
        logic [CHAN_W-1:0] res;
        sum = {1'b0, c} + {1'b0, step};
        if (lit) begin
            res = (sum <= {1'b0, t}) ? sum[CHAN_W-1:0] : t;
        end else begin
            res = (c >= step) ? c - step : '0;
        end
        return res;
    endfunction

    function automatic logic [GRB_W-1:0] word_update(
        input logic [GRB_W-1:0]  w,
        input logic [GRB_W-1:0]  t,
        input logic [CHAN_W-1:0] step,
        input logic              lit
    );
        logic [GRB_W-1:0] res;
        for (int i = 0; i < GRB_W / CHAN_W; i++) begin
            res[i*CHAN_W +: CHAN_W] = chan_update(w[i*CHAN_W +: CHAN_W],
                                                  t[i*CHAN_W +: CHAN_W], step, lit);
        end
        return res;
    endfunction

endpackage

FILE: src/led_bar_graph_fade.sv
// LED bar graph fade, top level: frame control, pixel memory and result register.
// Depends on lbgf_pkg and led_bar_graph_fade_assert.svh.
//
// Each accepted request names a bar and a load byte and yields PIXELS pixel results,
// index 0 upward, the final one flagged by m_last. The lit count is
// round(load*PIXELS/255); bar 0 lights from the bottom, bar 1 from the top. A frame
// first takes the request, then forms the lit count, then reads the first pixel, and then
// does one read-modify-write of the pixel memory per cycle through its single read port,
// unless back-pressure on the output holds it. One frame is worked on at a time; the next
// request is taken as soon as the final result sits in the output register. Pixel
// memory entries read as zero until first written, so no clearing pass follows reset.
// Configuration writes are always taken and act from the next cycle, including on a
// frame in progress, so make them only while no frame is being worked on.
`include "led_bar_graph_fade_assert.svh"

module led_bar_graph_fade
    import lbgf_pkg::*;
#(
    parameter int PIXELS = 13
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_bar,
    input  logic [7:0]         s_load,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [INDEX_W-1:0] m_pixel_index,
    output logic [GRB_W-1:0]   m_pixel_grb,
    output logic               m_last,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [GRB_W-1:0]   cfg_data
);

    localparam int IDX_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int CNT_W   = $clog2(PIXELS + 1);
    localparam int CMP_W   = CNT_W + 1;
    localparam int PROD_W  = 8 + CNT_W;
    localparam int Q_W     = PROD_W + 1;
    localparam int DEPTH   = 2 * PIXELS;
    localparam int ADDR_W  = $clog2(DEPTH);

    lbgf_state_t state_reg, state_next;

    logic [GRB_W-1:0]  color0_reg, color0_next;
    logic [GRB_W-1:0]  color1_reg, color1_next;
    logic [CHAN_W-1:0] step_reg, step_next;

    logic              bar_reg, bar_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic              rd_more_reg, rd_more_next;
    logic [IDX_W-1:0]  cur_ptr_reg, cur_ptr_next;
    logic              inflight_reg, inflight_next;

    logic               m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [GRB_W-1:0]   grb_reg, grb_next;
    logic               last_reg, last_next;

    logic [GRB_W-1:0] pixel_mem [DEPTH];
    logic [DEPTH-1:0] written_reg, written_next;
    logic [GRB_W-1:0] mem_q_reg;
    logic             hit_reg;

    logic              accept;
    logic              run;
    logic              out_free;
    logic              consume;
    logic              rd_en;
    logic              finish;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [Q_W-1:0]    q_x1;
    logic [Q_W-1:0]    q_sum;
    logic              lit;
    logic [GRB_W-1:0]  old_word;
    logic [GRB_W-1:0]  new_word;
    logic [CMP_W-1:0]  ptr_ext;
    logic [CMP_W-1:0]  cnt_ext;

    // FSM next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_PREP;
            ST_PREP: state_next = ST_RUN;
            ST_RUN:  if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_ready = 1'b0;
        run     = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_PREP: ;
            ST_RUN:  run = 1'b1;
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign consume   = run && inflight_reg && out_free;
    assign rd_en     = run && rd_more_reg && (!inflight_reg || consume);
    assign finish    = consume && (cur_ptr_reg == IDX_W'(PIXELS - 1));

    assign rd_addr = bar_reg ? ADDR_W'(PIXELS) + ADDR_W'(rd_ptr_reg) : ADDR_W'(rd_ptr_reg);
    assign wr_addr = bar_reg ? ADDR_W'(PIXELS) + ADDR_W'(cur_ptr_reg) : ADDR_W'(cur_ptr_reg);

    // x/255 for x below 2^16: (x+1 + ((x+1)>>8)) >> 8, x = load*PIXELS + 127
    assign q_x1  = Q_W'(prod_reg) + Q_W'(ROUND_BIAS + 1);
    assign q_sum = q_x1 + (q_x1 >> 8);

    assign ptr_ext  = CMP_W'(cur_ptr_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign lit      = bar_reg ? (ptr_ext + cnt_ext >= CMP_W'(PIXELS)) : (ptr_ext < cnt_ext);
    assign old_word = hit_reg ? mem_q_reg : '0;
    assign new_word = word_update(old_word, bar_reg ? color1_reg : color0_reg, step_reg, lit);

    always_comb begin
        color0_next = color0_reg;
        color1_next = color1_reg;
        step_next   = step_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_COLOR_BAR0: color0_next = cfg_data;
                REG_COLOR_BAR1: color1_next = cfg_data;
                REG_FADE_STEP:  step_next   = cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        bar_next      = bar_reg;
        prod_next     = prod_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_more_next  = rd_more_reg;
        cur_ptr_next  = cur_ptr_reg;
        inflight_next = inflight_reg;
        if (accept) begin
            bar_next  = s_bar;
            prod_next = PROD_W'(s_load) * PROD_W'(PIXELS);
        end
        if (state_reg == ST_PREP) begin
            count_next    = q_sum[8 +: CNT_W];
            rd_ptr_next   = '0;
            rd_more_next  = 1'b1;
            inflight_next = 1'b0;
        end
        if (rd_en) begin
            cur_ptr_next  = rd_ptr_reg;
            inflight_next = 1'b1;
            rd_ptr_next   = rd_ptr_reg + 1'b1;
            rd_more_next  = (rd_ptr_reg != IDX_W'(PIXELS - 1));
        end else if (consume) begin
            inflight_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        idx_next     = idx_reg;
        grb_next     = grb_reg;
        last_next    = last_reg;
        written_next = written_reg;
        if (consume) begin
            m_valid_next          = 1'b1;
            idx_next              = INDEX_W'(cur_ptr_reg);
            grb_next              = new_word;
            last_next             = (cur_ptr_reg == IDX_W'(PIXELS - 1));
            written_next[wr_addr] = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            color0_reg   <= GRB_W'(24'h0000FF);
            color1_reg   <= GRB_W'(24'h00FF00);
            step_reg     <= CHAN_W'(4);
            rd_more_reg  <= 1'b0;
            inflight_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            written_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            color0_reg   <= color0_next;
            color1_reg   <= color1_next;
            step_reg     <= step_next;
            rd_more_reg  <= rd_more_next;
            inflight_reg <= inflight_next;
            m_valid_reg  <= m_valid_next;
            written_reg  <= written_next;
        end
    end

    always_ff @(posedge aclk) begin
        bar_reg     <= bar_next;
        prod_reg    <= prod_next;
        count_reg   <= count_next;
        rd_ptr_reg  <= rd_ptr_next;
        cur_ptr_reg <= cur_ptr_next;
        idx_reg     <= idx_next;
        grb_reg     <= grb_next;
        last_reg    <= last_next;
    end

    // pixel memory: one write, one registered read; frames never overlap on an entry
    always_ff @(posedge aclk) begin
        if (consume) begin
            pixel_mem[wr_addr] <= new_word;
        end
        if (rd_en) begin
            mem_q_reg <= pixel_mem[rd_addr];
            hit_reg   <= written_reg[rd_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_index = idx_reg;
    assign m_pixel_grb   = grb_reg;
    assign m_last        = last_reg;

    `LBGF_ASSERT_NEXT(a_hold_on_stall, inflight_reg && !out_free,
                      inflight_reg && $stable(cur_ptr_reg) && $stable(mem_q_reg))
    `LBGF_ASSERT_NEXT(a_finish_idle, finish, (state_reg == ST_IDLE) && m_valid && m_last)
    `LBGF_ASSERT_NOW(a_no_stray_read, state_reg != ST_RUN, !inflight_reg && !rd_en)
    `LBGF_ASSERT_NOW(a_addr_range, rd_en, rd_addr < ADDR_W'(DEPTH))

endmodule
